### sv/p2tsm_pkg.sv
package p2tsm_pkg;

  // Width of one barycentric gradient component, of their products and of the dot products.
  localparam int NvW  = 33;
  localparam int PrW  = 66;
  localparam int GW   = 67;
  // Width of the weighted sum of dot products for one entry.
  localparam int PW   = 72;
  // Width of the determinant magnitude and of the rounding divisor twelve times |det|.
  localparam int DetW = 64;
  localparam int DW   = 68;
  // Quotient bits kept by the divider; a larger quotient saturates unless the entry is degenerate.
  localparam int QW   = 32;

  localparam int NumTerms = 6;
  localparam int NumNodes = 6;
  localparam logic [2:0] NodeLast = 3'd5;

  localparam logic signed [31:0] ValueMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ValueMin = 32'sh8000_0000;

  typedef logic signed [4:0]    wgt_t;
  typedef logic signed [GW-1:0] gval_t;

  // Dot products and divisor of one triangle, handed from the geometry front end to the sequencer.
  typedef struct packed {
    gval_t [NumTerms-1:0] g;
    logic [DW-2:0]        den6;
    logic                 degen;
  } tri_t;

  // Per-entry tags that travel alongside the arithmetic.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       neg;
    logic       degen;
    logic       last;
  } meta_t;

  localparam wgt_t WZ  = 5'sd0;
  localparam wgt_t WM1 = -5'sd1;
  localparam wgt_t W3  = 5'sd3;
  localparam wgt_t W4  = 5'sd4;
  localparam wgt_t W8  = 5'sd8;

  // Weights on G11, G22, G33, G12, G13, G23 for each entry, indexed by row and column.
  localparam wgt_t EntryWeights [NumNodes][NumNodes][NumTerms] = '{
    '{'{W3,WZ,WZ,WZ,WZ,WZ}, '{WZ,WZ,WZ,WM1,WZ,WZ}, '{WZ,WZ,WZ,WZ,WM1,WZ},
      '{WZ,WZ,WZ,W4,WZ,WZ}, '{WZ,WZ,WZ,WZ,WZ,WZ},  '{WZ,WZ,WZ,WZ,W4,WZ}},
    '{'{WZ,WZ,WZ,WM1,WZ,WZ}, '{WZ,W3,WZ,WZ,WZ,WZ}, '{WZ,WZ,WZ,WZ,WZ,WM1},
      '{WZ,WZ,WZ,W4,WZ,WZ},  '{WZ,WZ,WZ,WZ,WZ,W4}, '{WZ,WZ,WZ,WZ,WZ,WZ}},
    '{'{WZ,WZ,WZ,WZ,WM1,WZ}, '{WZ,WZ,WZ,WZ,WZ,WM1}, '{WZ,WZ,W3,WZ,WZ,WZ},
      '{WZ,WZ,WZ,WZ,WZ,WZ},  '{WZ,WZ,WZ,WZ,WZ,W4},  '{WZ,WZ,WZ,WZ,W4,WZ}},
    '{'{WZ,WZ,WZ,W4,WZ,WZ}, '{WZ,WZ,WZ,W4,WZ,WZ}, '{WZ,WZ,WZ,WZ,WZ,WZ},
      '{W8,W8,WZ,W8,WZ,WZ}, '{WZ,W4,WZ,W4,W8,W4}, '{W4,WZ,WZ,W4,W4,W8}},
    '{'{WZ,WZ,WZ,WZ,WZ,WZ}, '{WZ,WZ,WZ,WZ,WZ,W4}, '{WZ,WZ,WZ,WZ,WZ,W4},
      '{WZ,W4,WZ,W4,W8,W4}, '{WZ,W8,W8,WZ,WZ,W8}, '{WZ,WZ,W4,W8,W4,W4}},
    '{'{WZ,WZ,WZ,WZ,W4,WZ}, '{WZ,WZ,WZ,WZ,WZ,WZ}, '{WZ,WZ,WZ,WZ,W4,WZ},
      '{W4,WZ,WZ,W4,W4,W8}, '{WZ,WZ,W4,W8,W4,W4}, '{W8,WZ,W8,WZ,W8,WZ}}
  };

endpackage

### sv/p2tsm_geom.sv
module p2tsm_geom (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] ab_x_i,
  input  logic signed [31:0] ab_y_i,
  input  logic signed [31:0] ac_x_i,
  input  logic signed [31:0] ac_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output p2tsm_pkg::tri_t    out_tri_o
);
  import p2tsm_pkg::*;

  localparam int PA [NumTerms] = '{0, 1, 2, 0, 0, 1};
  localparam int PB [NumTerms] = '{0, 1, 2, 1, 2, 2};

  logic [3:0] v_q;
  logic [3:0] en;

  logic signed [NvW-1:0]  n_q [3][2];
  logic signed [31:0]     bx_q, by_q, cx_q, cy_q;
  logic signed [PrW-1:0]  prod_q [NumTerms][2];
  logic signed [63:0]     dp_q [2];
  logic signed [GW-1:0]   g2_q [NumTerms];
  logic signed [64:0]     det_q;
  logic signed [GW-1:0]   g3_q [NumTerms];
  logic [DW-2:0]          den6_q;
  logic                   degen_q;
  logic [DetW-1:0]        det_abs;

  // Elastic stages: a stage takes new data when it is empty or its successor moves on.
  assign en[3] = !v_q[3] || out_ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      n_q[0][0] <= NvW'(ab_y_i) - NvW'(ac_y_i);
      n_q[0][1] <= NvW'(ac_x_i) - NvW'(ab_x_i);
      n_q[1][0] <= NvW'(ac_y_i);
      n_q[1][1] <= -NvW'(ac_x_i);
      n_q[2][0] <= -NvW'(ab_y_i);
      n_q[2][1] <= NvW'(ab_x_i);
      bx_q <= ab_x_i;
      by_q <= ab_y_i;
      cx_q <= ac_x_i;
      cy_q <= ac_y_i;
    end
    if (en[1]) begin
      for (int k = 0; k < NumTerms; k++) begin
        prod_q[k][0] <= n_q[PA[k]][0] * n_q[PB[k]][0];
        prod_q[k][1] <= n_q[PA[k]][1] * n_q[PB[k]][1];
      end
      dp_q[0] <= bx_q * cy_q;
      dp_q[1] <= cx_q * by_q;
    end
    if (en[2]) begin
      for (int k = 0; k < NumTerms; k++) begin
        g2_q[k] <= GW'(prod_q[k][0]) + GW'(prod_q[k][1]);
      end
      det_q <= 65'(dp_q[0]) - 65'(dp_q[1]);
    end
    if (en[3]) begin
      g3_q    <= g2_q;
      den6_q  <= ((DW-1)'(det_abs) << 2) + ((DW-1)'(det_abs) << 1);
      degen_q <= (det_q == '0);
    end
  end

  assign det_abs = det_q[64] ? DetW'(-det_q) : DetW'(det_q);

  always_comb begin
    for (int k = 0; k < NumTerms; k++) begin
      out_tri_o.g[k] = g3_q[k];
    end
    out_tri_o.den6  = den6_q;
    out_tri_o.degen = degen_q;
  end

endmodule

### sv/p2tsm_seq.sv
module p2tsm_seq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  p2tsm_pkg::tri_t                      in_tri_i,
  output logic                                 out_valid_o,
  output logic [p2tsm_pkg::PW+FRAC_BITS+1:0]   out_num_o,
  output logic [p2tsm_pkg::DW-1:0]             out_den_o,
  output p2tsm_pkg::meta_t                     out_meta_o
);
  import p2tsm_pkg::*;

  localparam int NW = PW + FRAC_BITS + 2;

  logic signed [GW-1:0] g_q [NumTerms];
  logic [DW-2:0]        den6_q;
  logic                 degen_q;
  logic                 act_q;
  logic [2:0]           row_q, col_q;
  logic                 last_issue, load;

  logic signed [PW-1:0] t_q [NumTerms];
  logic signed [PW-1:0] s_q [3];
  logic signed [PW-1:0] p_q;
  logic [DW-2:0]        den1_q, den2_q, den3_q;
  meta_t                m1_q, m2_q, m3_q, m4_q;
  logic [3:0]           v_q;
  logic [NW-1:0]        num_q;
  logic [DW-1:0]        den_q;
  logic [PW-1:0]        p_abs;

  assign last_issue = act_q && (row_q == NodeLast) && (col_q == NodeLast);
  assign in_ready_o = !act_q || last_issue;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      row_q <= '0;
      col_q <= '0;
      v_q   <= '0;
    end else begin
      v_q <= {v_q[2:0], act_q};
      if (load) begin
        act_q <= 1'b1;
        row_q <= '0;
        col_q <= '0;
      end else if (act_q) begin
        if (last_issue) begin
          act_q <= 1'b0;
        end else if (col_q == NodeLast) begin
          col_q <= '0;
          row_q <= row_q + 3'd1;
        end else begin
          col_q <= col_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < NumTerms; k++) begin
        g_q[k] <= $signed(in_tri_i.g[k]);
      end
      den6_q  <= in_tri_i.den6;
      degen_q <= in_tri_i.degen;
    end
  end

  // Scale each dot product by its small weight, sum in two levels, then form the rounded numerator.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumTerms; k++) begin
      t_q[k] <= g_q[k] * EntryWeights[row_q][col_q][k];
    end
    m1_q.row   <= row_q;
    m1_q.col   <= col_q;
    m1_q.neg   <= 1'b0;
    m1_q.degen <= degen_q;
    m1_q.last  <= last_issue;
    den1_q     <= den6_q;

    s_q[0] <= t_q[0] + t_q[1];
    s_q[1] <= t_q[2] + t_q[3];
    s_q[2] <= t_q[4] + t_q[5];
    m2_q   <= m1_q;
    den2_q <= den1_q;

    p_q    <= s_q[0] + s_q[1] + s_q[2];
    m3_q   <= m2_q;
    den3_q <= den2_q;

    num_q <= (NW'(p_abs) << (FRAC_BITS + 1)) + NW'(den3_q);
    den_q <= {den3_q, 1'b0};
    m4_q  <= '{row: m3_q.row, col: m3_q.col, neg: p_q[PW-1], degen: m3_q.degen,
               last: m3_q.last};
  end

  assign p_abs = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);

  assign out_valid_o = v_q[3];
  assign out_num_o   = num_q;
  assign out_den_o   = den_q;
  assign out_meta_o  = m4_q;

endmodule

### sv/p2tsm_div.sv
module p2tsm_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [p2tsm_pkg::PW+FRAC_BITS+1:0] in_num_i,
  input  logic [p2tsm_pkg::DW-1:0]           in_den_i,
  input  p2tsm_pkg::meta_t                   in_meta_i,
  output logic                               out_valid_o,
  output logic signed [31:0]                 out_value_o,
  output logic                               out_sat_o,
  output p2tsm_pkg::meta_t                   out_meta_o
);
  import p2tsm_pkg::*;

  localparam int NW = PW + FRAC_BITS + 2;
  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [XW-1:0] r_q   [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  meta_t         m_q   [QW+1];
  logic          big_q [QW+1];
  logic [QW:0]   v_q;

  logic                out_valid_q;
  logic signed [31:0]  value_q;
  logic                sat_q;
  meta_t               meta_q;
  logic [QW-1:0]       q_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v_q         <= {v_q[QW-1:0], in_valid_i};
      out_valid_q <= v_q[QW];
    end
  end

  // Entry stage: a quotient of 2^32 or more saturates whatever the sign, unless degenerate.
  always_ff @(posedge clk_i) begin
    r_q[0]   <= XW'(in_num_i);
    d_q[0]   <= in_den_i;
    q_q[0]   <= '0;
    m_q[0]   <= in_meta_i;
    big_q[0] <= XW'(in_num_i) >= (XW'(in_den_i) << QW);
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int Bit = QW - s;
    logic [XW-1:0] sub;
    logic          ge;
    assign sub = XW'(d_q[s-1]) << Bit;
    assign ge  = r_q[s-1] >= sub;
    always_ff @(posedge clk_i) begin
      r_q[s]   <= ge ? r_q[s-1] - sub : r_q[s-1];
      q_q[s]   <= q_q[s-1] | (QW'(ge) << Bit);
      d_q[s]   <= d_q[s-1];
      m_q[s]   <= m_q[s-1];
      big_q[s] <= big_q[s-1];
    end
  end

  assign q_fin = q_q[QW];

  always_ff @(posedge clk_i) begin
    meta_q <= m_q[QW];
    if (m_q[QW].degen) begin
      value_q <= '0;
      sat_q   <= 1'b0;
    end else if (!m_q[QW].neg) begin
      if (big_q[QW] || q_fin > QW'(ValueMax)) begin
        value_q <= ValueMax;
        sat_q   <= 1'b1;
      end else begin
        value_q <= $signed(q_fin);
        sat_q   <= 1'b0;
      end
    end else begin
      if (big_q[QW] || q_fin > QW'(ValueMin)) begin
        value_q <= ValueMin;
        sat_q   <= 1'b1;
      end else begin
        value_q <= $signed(-q_fin);
        sat_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = value_q;
  assign out_sat_o   = sat_q;
  assign out_meta_o  = meta_q;

endmodule

### sv/p2_triangle_stiffness_matrix_unit.sv
// Quadratic triangle element stiffness matrix unit.
// A triangle is offered on edge_ab_x_i/edge_ab_y_i/edge_ac_x_i/edge_ac_y_i (signed Q16.16)
// and is taken as an item at a rising edge where start is high and busy is low.
// For each item the unit emits the 36 entries of the 6x6 matrix in row-major order,
// one entry per cycle on consecutive cycles, each marked by valid_o for one cycle.
// matrix_row_o/matrix_col_o give the node pair, last_entry_o marks row 5 column 5,
// degenerate_o flags a zero determinant (all entries then zero) and saturated_o flags
// an entry clipped to the 32-bit signed range.
// An item's entries appear after it has passed the four-stage front end, the sequencer
// and the pipelined divider. The single result channel sets sustained throughput: a
// waiting item's entries follow the previous item's last entry directly. The front
// end buffers items while the entry sequencer is busy; busy rises only once it is full.
// Reset clears every valid bit and the sequencer; no item is in flight afterwards.
// The receiver cannot stall: once issued, an entry flows through the pipeline to the
// result ports without pause.
module p2_triangle_stiffness_matrix_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] edge_ab_x_i,
  input  logic signed [31:0] edge_ab_y_i,
  input  logic signed [31:0] edge_ac_x_i,
  input  logic signed [31:0] edge_ac_y_i,
  output logic               valid_o,
  output logic [2:0]         matrix_row_o,
  output logic [2:0]         matrix_col_o,
  output logic signed [31:0] entry_value_o,
  output logic               saturated_o,
  output logic               degenerate_o,
  output logic               last_entry_o
);
  import p2tsm_pkg::*;

  localparam int NW = PW + FRAC_BITS + 2;

  logic          geom_ready, tri_valid, tri_ready;
  tri_t          tri_data;
  logic          ent_valid;
  logic [NW-1:0] ent_num;
  logic [DW-1:0] ent_den;
  meta_t         ent_meta;
  meta_t         res_meta;

  // The geometry front end forms the gradient dot products and the determinant.
  p2tsm_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .in_ready_o  (geom_ready),
    .ab_x_i      (edge_ab_x_i),
    .ab_y_i      (edge_ab_y_i),
    .ac_x_i      (edge_ac_x_i),
    .ac_y_i      (edge_ac_y_i),
    .out_valid_o (tri_valid),
    .out_ready_i (tri_ready),
    .out_tri_o   (tri_data)
  );

  assign busy = !geom_ready;

  // The sequencer walks the 36 entries and builds each rounded numerator.
  p2tsm_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tri_valid),
    .in_ready_o  (tri_ready),
    .in_tri_i    (tri_data),
    .out_valid_o (ent_valid),
    .out_num_o   (ent_num),
    .out_den_o   (ent_den),
    .out_meta_o  (ent_meta)
  );

  // The pipelined divider produces one quotient per cycle and applies saturation.
  p2tsm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ent_valid),
    .in_num_i    (ent_num),
    .in_den_i    (ent_den),
    .in_meta_i   (ent_meta),
    .out_valid_o (valid_o),
    .out_value_o (entry_value_o),
    .out_sat_o   (saturated_o),
    .out_meta_o  (res_meta)
  );

  assign matrix_row_o = res_meta.row;
  assign matrix_col_o = res_meta.col;
  assign degenerate_o = res_meta.degen;
  assign last_entry_o = res_meta.last;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> entry_value_o == '0 && !saturated_o)
    else $error("degenerate entry is not zero");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturated_o |-> entry_value_o == ValueMax || entry_value_o == ValueMin)
    else $error("saturated entry is not at a range limit");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_entry_o |-> matrix_row_o == NodeLast && matrix_col_o == NodeLast)
    else $error("last entry flag away from row 5 column 5");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_entry_o |=> valid_o)
    else $error("gap inside a matrix burst");

endmodule
